// ===== design/ita_pkg.sv =====
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types, character codes and helper functions for the integer to
// ASCII formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package ita_pkg;

  // default value width and fixed field widths
  localparam int DEF_VALUE_WIDTH = 32;
  localparam int IN_VALUE_W      = 32;
  localparam int CHAR_W          = 8;
  // character count width, holds a run of up to 68 characters (64-bit binary)
  localparam int CNT_W           = 7;

  // character codes
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ONE  = 8'h31;
  localparam logic [CHAR_W-1:0] CH_X    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_B    = 8'h62;
  localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_A_M10 = 8'h37;  // 'A' - 10

  // format codes
  typedef enum logic [1:0] {
    FMT_HEX  = 2'd0,
    FMT_DEC  = 2'd1,
    FMT_BIN  = 2'd2,
    FMT_NONE = 2'd3
  } fmt_t;

  // back end states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } back_state_t;

  // classified request handed from the front end to the back end
  typedef struct packed {
    fmt_t             fmt;
    logic [CNT_W-1:0] n_chars;   // total characters in the run
    logic [CNT_W-1:0] dig_end;   // position just after the last digit
  } cmd_ctrl_t;

  // number of decimal digits of 2^w - 1
  function automatic int dec_digit_count(input int w);
    logic [63:0] m;
    int          n;
    m = {64{1'b1}} >> (64 - w);
    n = 0;
    do begin
      n = n + 1;
      m = m / 10;
    end while (m != 64'd0);
    return n;
  endfunction

  // upper-case hex symbol of one nibble
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] ch;
    if (nib < 4'd10) begin
      ch = CH_ZERO + {4'h0, nib};
    end else begin
      ch = CH_A_M10 + {4'h0, nib};
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== design/ita_front.sv =====
// ----------------------------------------------------------------------------
// ita_front
// Accepts requests, trims the value to its width and works out the run
// layout; requests that produce no character are dropped here.
// ----------------------------------------------------------------------------
`default_nettype none

module ita_front #(
  parameter int VALUE_WIDTH = ita_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_action,
  input  wire logic [ita_pkg::IN_VALUE_W-1:0] in_number_value,
  input  wire logic                          in_append_newline,
  input  wire logic                          q_full,
  output logic                               q_push,
  output ita_pkg::cmd_ctrl_t                 q_ctrl,
  output logic [VALUE_WIDTH-1:0]             q_value
);

  localparam int ND_HEX = (VALUE_WIDTH + 3) / 4;
  localparam int ND_DEC = ita_pkg::dec_digit_count(VALUE_WIDTH);

  ita_pkg::fmt_t                  fmt;
  logic [ita_pkg::CNT_W-1:0]      dig_end;
  logic [ita_pkg::CNT_W-1:0]      n_chars;

  // digit span per format, prefix included
  always_comb begin
    fmt = ita_pkg::fmt_t'(in_action);
    case (fmt)
      ita_pkg::FMT_HEX: dig_end = ita_pkg::CNT_W'(ND_HEX + 2);
      ita_pkg::FMT_DEC: dig_end = ita_pkg::CNT_W'(ND_DEC);
      ita_pkg::FMT_BIN: dig_end = ita_pkg::CNT_W'(VALUE_WIDTH + 2);
      default:          dig_end = '0;
    endcase
    n_chars = dig_end + (in_append_newline ? ita_pkg::CNT_W'(2) : '0);
  end

  // queue hand-off, empty runs are taken and discarded
  assign in_ready       = !q_full;
  assign q_push         = in_valid && !q_full && (n_chars != '0);
  assign q_ctrl.fmt     = fmt;
  assign q_ctrl.n_chars = n_chars;
  assign q_ctrl.dig_end = dig_end;
  assign q_value        = VALUE_WIDTH'(in_number_value);

endmodule

`default_nettype wire

// ===== design/ita_queue.sv =====
// ----------------------------------------------------------------------------
// ita_queue
// Two-entry request queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module ita_queue #(
  parameter int VALUE_WIDTH = ita_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire ita_pkg::cmd_ctrl_t       push_ctrl,
  input  wire logic [VALUE_WIDTH-1:0]   push_value,
  output logic                          full,
  output logic                          not_empty,
  input  wire logic                     pop,
  output ita_pkg::cmd_ctrl_t            pop_ctrl,
  output logic [VALUE_WIDTH-1:0]        pop_value
);

  ita_pkg::cmd_ctrl_t       ctrl_mem [2];
  logic [VALUE_WIDTH-1:0]   value_mem [2];
  logic                     wr_ptr_r, wr_ptr_nxt;
  logic                     rd_ptr_r, rd_ptr_nxt;
  logic [1:0]               count_r, count_nxt;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ctrl_mem[wr_ptr_r]  <= push_ctrl;
      value_mem[wr_ptr_r] <= push_value;
    end
  end

  assign full      = count_r[1];
  assign not_empty = count_r != 2'd0;
  assign pop_ctrl  = ctrl_mem[rd_ptr_r];
  assign pop_value = value_mem[rd_ptr_r];

endmodule

`default_nettype wire

// ===== design/ita_back.sv =====
// ----------------------------------------------------------------------------
// ita_back
// Takes queued requests, converts to BCD by shift-and-add-3 where needed and
// streams the characters through an output register, one per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ita_back #(
  parameter int VALUE_WIDTH = ita_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_not_empty,
  output logic                               q_pop,
  input  wire ita_pkg::cmd_ctrl_t            q_ctrl,
  input  wire logic [VALUE_WIDTH-1:0]        q_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ita_pkg::CHAR_W-1:0]         out_ascii_char,
  output logic                               out_last_char
);

  localparam int ND_HEX = (VALUE_WIDTH + 3) / 4;
  localparam int HEX_W  = 4 * ND_HEX;
  localparam int ND_DEC = ita_pkg::dec_digit_count(VALUE_WIDTH);
  localparam int SH_W   = 4 * ND_DEC;
  localparam int CONV_W = $clog2(VALUE_WIDTH + 1);

  ita_pkg::back_state_t           state_r, state_nxt;
  ita_pkg::fmt_t                  fmt_r, fmt_nxt;
  logic [ita_pkg::CNT_W-1:0]      n_chars_r, n_chars_nxt;
  logic [ita_pkg::CNT_W-1:0]      dig_end_r, dig_end_nxt;
  logic [ita_pkg::CNT_W-1:0]      pos_r, pos_nxt;
  logic [CONV_W-1:0]              conv_cnt_r, conv_cnt_nxt;
  logic [VALUE_WIDTH-1:0]         src_r, src_nxt;
  logic [SH_W-1:0]                digits_r, digits_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [ita_pkg::CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                           out_last_r, out_last_nxt;

  logic [SH_W-1:0]                bcd_adj;
  logic [ita_pkg::CHAR_W-1:0]     emit_char;
  logic                           emit_digit;
  logic                           has_prefix;
  logic                           slot_free;
  logic [ita_pkg::CNT_W-1:0]      pos_inc;

  // add 3 to every BCD nibble of five or more
  always_comb begin
    for (int k = 0; k < ND_DEC; k++) begin
      if (digits_r[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = digits_r[4*k +: 4] + 4'd3;
      end else begin
        bcd_adj[4*k +: 4] = digits_r[4*k +: 4];
      end
    end
  end

  // character at the current run position
  always_comb begin
    has_prefix = (fmt_r == ita_pkg::FMT_HEX) || (fmt_r == ita_pkg::FMT_BIN);
    emit_digit = 1'b0;
    if (has_prefix && pos_r == '0) begin
      emit_char = ita_pkg::CH_ZERO;
    end else if (has_prefix && pos_r == ita_pkg::CNT_W'(1)) begin
      emit_char = (fmt_r == ita_pkg::FMT_HEX) ? ita_pkg::CH_X : ita_pkg::CH_B;
    end else if (pos_r < dig_end_r) begin
      emit_digit = 1'b1;
      if (fmt_r == ita_pkg::FMT_BIN) begin
        emit_char = digits_r[SH_W-1] ? ita_pkg::CH_ONE : ita_pkg::CH_ZERO;
      end else begin
        emit_char = ita_pkg::hex_char(digits_r[SH_W-1 -: 4]);
      end
    end else if (pos_r == dig_end_r) begin
      emit_char = ita_pkg::CH_CR;
    end else begin
      emit_char = ita_pkg::CH_LF;
    end
  end

  // sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    fmt_nxt       = fmt_r;
    n_chars_nxt   = n_chars_r;
    dig_end_nxt   = dig_end_r;
    pos_nxt       = pos_r;
    conv_cnt_nxt  = conv_cnt_r;
    src_nxt       = src_r;
    digits_nxt    = digits_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    slot_free     = !out_valid_r || out_ready;
    out_valid_nxt = out_valid_r && !out_ready;
    pos_inc       = pos_r + ita_pkg::CNT_W'(1);

    case (state_r)
      ita_pkg::ST_IDLE: begin
        if (q_not_empty) begin
          q_pop        = 1'b1;
          fmt_nxt      = q_ctrl.fmt;
          n_chars_nxt  = q_ctrl.n_chars;
          dig_end_nxt  = q_ctrl.dig_end;
          pos_nxt      = '0;
          src_nxt      = q_value;
          conv_cnt_nxt = CONV_W'(VALUE_WIDTH);
          if (q_ctrl.fmt == ita_pkg::FMT_DEC) begin
            digits_nxt = '0;
            state_nxt  = ita_pkg::ST_CONV;
          end else if (q_ctrl.fmt == ita_pkg::FMT_BIN) begin
            digits_nxt = SH_W'(q_value) << (SH_W - VALUE_WIDTH);
            state_nxt  = ita_pkg::ST_EMIT;
          end else begin
            digits_nxt = SH_W'(HEX_W'(q_value)) << (SH_W - HEX_W);
            state_nxt  = ita_pkg::ST_EMIT;
          end
        end
      end
      ita_pkg::ST_CONV: begin
        digits_nxt   = {bcd_adj[SH_W-2:0], src_r[VALUE_WIDTH-1]};
        src_nxt      = src_r << 1;
        conv_cnt_nxt = conv_cnt_r - CONV_W'(1);
        if (conv_cnt_r == CONV_W'(1)) begin
          state_nxt = ita_pkg::ST_EMIT;
        end
      end
      ita_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = emit_char;
          out_last_nxt  = (pos_inc == n_chars_r);
          pos_nxt       = pos_inc;
          if (emit_digit) begin
            digits_nxt = (fmt_r == ita_pkg::FMT_BIN) ? (digits_r << 1) : (digits_r << 4);
          end
          if (pos_inc == n_chars_r) begin
            state_nxt = ita_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ita_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ita_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    fmt_r      <= fmt_nxt;
    n_chars_r  <= n_chars_nxt;
    dig_end_r  <= dig_end_nxt;
    pos_r      <= pos_nxt;
    conv_cnt_r <= conv_cnt_nxt;
    src_r      <= src_nxt;
    digits_r   <= digits_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_ascii_char = out_char_r;
  assign out_last_char  = out_last_r;

endmodule

`default_nettype wire

// ===== design/integer_to_ascii_formatter_top.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Formats an unsigned value as hex, decimal or binary ASCII text, one
// character per output request, with an optional CR LF and a last marker.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes a format code, a value and a
//   newline flag. Output channel (out_valid/out_ready) gives one character
//   per request; out_last_char marks the final character of a run.
//   Hex runs are "0x" plus 8 digits, decimal runs 10 digits with leading
//   zeros, binary runs "0b" plus 32 bits (default width); CR LF follows when
//   the flag is set. A request with format none and no newline gives nothing.
//   The request is written into the queue, popped into the back end's
//   working registers when it is idle, and its first character is then
//   loaded into the output register. The back end emits one character
//   per cycle while out_ready is high, and returns to idle after each run
//   to take the next request from the queue; a decimal request first
//   passes through the shift-and-add-3 BCD converter.
//   A two-entry queue lets the front end take requests while a run is
//   being emitted; in_ready drops only when the queue is full.
//   When the receiver stalls, the current character is held in the output
//   register and the back end waits. Reset empties the queue and the
//   output register and returns the back end to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_formatter_top #(
  parameter int VALUE_WIDTH = ita_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_action,
  input  wire logic [ita_pkg::IN_VALUE_W-1:0] in_number_value,
  input  wire logic                           in_append_newline,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ita_pkg::CHAR_W-1:0]          out_ascii_char,
  output logic                                out_last_char
);

  logic                     q_full;
  logic                     q_push;
  logic                     q_not_empty;
  logic                     q_pop;
  ita_pkg::cmd_ctrl_t       push_ctrl;
  ita_pkg::cmd_ctrl_t       pop_ctrl;
  logic [VALUE_WIDTH-1:0]   push_value;
  logic [VALUE_WIDTH-1:0]   pop_value;

  // request intake and classification
  ita_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_number_value  (in_number_value),
    .in_append_newline(in_append_newline),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_ctrl           (push_ctrl),
    .q_value          (push_value)
  );

  // request queue
  ita_queue #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_ctrl (push_ctrl),
    .push_value(push_value),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .pop_ctrl  (pop_ctrl),
    .pop_value (pop_value)
  );

  // conversion and character streaming
  ita_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_pop         (q_pop),
    .q_ctrl        (pop_ctrl),
    .q_value       (pop_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ascii_char(out_ascii_char),
    .out_last_char (out_last_char)
  );

endmodule

`default_nettype wire

// ===== tb/tb_integer_to_ascii_formatter_top.sv =====
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter_top
// Self-checking bench for the integer to ASCII formatter. A driver feeds
// format requests from a queue and predicts the text of every accepted one;
// a monitor checks each character and last marker against that text. Both
// sides idle in random bursts, then run flat out at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_integer_to_ascii_formatter_top;

  localparam int HALF_PERIOD = 6;
  localparam int DEC_DIGITS  = 10;
  localparam int HEX_DIGITS  = 8;
  localparam int VAL_W       = 32;
  localparam logic [ita_pkg::CHAR_W-1:0] SYM_A = 8'h41;

  typedef struct {
    ita_pkg::fmt_t action;
    logic [31:0]   value;
    logic          newline;
    logic          wait_drained;
    int            gap_pct;
    int            stall_pct;
  } fmt_request_t;

  typedef struct {
    logic [ita_pkg::CHAR_W-1:0] ch;
    logic                       is_last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_action = ita_pkg::FMT_HEX;
  logic [ita_pkg::IN_VALUE_W-1:0] in_number_value = '0;
  logic in_append_newline = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ita_pkg::CHAR_W-1:0] out_ascii_char;
  logic out_last_char;

  fmt_request_t queued_requests[$];
  text_char_t   pending_chars[$];
  int           error_count = 0;
  int           send_gap = 0;
  int           recv_stall = 0;
  int           rx_stall_pct = 0;
  int           phase_gap_pct = 0;
  int           phase_stall_pct = 0;

  integer_to_ascii_formatter_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_number_value   (in_number_value),
    .in_append_newline (in_append_newline),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ascii_char    (out_ascii_char),
    .out_last_char     (out_last_char)
  );

  // clock
  always #HALF_PERIOD clk = ~clk;

  // expected text of one request, appended to the store of pending characters
  function automatic void predict_text(input ita_pkg::fmt_t f, input logic [31:0] v,
                                       input logic nl);
    logic [ita_pkg::CHAR_W-1:0] txt[$];
    longint unsigned            rem;
    logic [3:0]                 nib;
    text_char_t                 tc;
    case (f)
      ita_pkg::FMT_HEX: begin
        txt.push_back(ita_pkg::CH_ZERO);
        txt.push_back(ita_pkg::CH_X);
        for (int k = HEX_DIGITS - 1; k >= 0; k--) begin
          nib = v[4*k +: 4];
          txt.push_back(nib < 4'd10 ? ita_pkg::CH_ZERO + ita_pkg::CHAR_W'(nib)
                                    : SYM_A + ita_pkg::CHAR_W'(nib - 4'd10));
        end
      end
      ita_pkg::FMT_DEC: begin
        rem = longint'(v);
        for (int k = 0; k < DEC_DIGITS; k++) begin
          txt.push_front(ita_pkg::CH_ZERO + ita_pkg::CHAR_W'(rem % 10));
          rem = rem / 10;
        end
      end
      ita_pkg::FMT_BIN: begin
        txt.push_back(ita_pkg::CH_ZERO);
        txt.push_back(ita_pkg::CH_B);
        for (int k = VAL_W - 1; k >= 0; k--) begin
          txt.push_back(v[k] ? ita_pkg::CH_ONE : ita_pkg::CH_ZERO);
        end
      end
      default: ;
    endcase
    if (nl) begin
      txt.push_back(ita_pkg::CH_CR);
      txt.push_back(ita_pkg::CH_LF);
    end
    foreach (txt[i]) begin
      tc.ch      = txt[i];
      tc.is_last = (i == txt.size() - 1);
      pending_chars.push_back(tc);
    end
  endfunction

  task automatic add_request(input ita_pkg::fmt_t f, input logic [31:0] v, input logic nl,
                             input logic drain = 1'b0);
    fmt_request_t r;
    r.action       = f;
    r.value        = v;
    r.newline      = nl;
    r.wait_drained = drain;
    r.gap_pct      = phase_gap_pct;
    r.stall_pct    = phase_stall_pct;
    queued_requests.push_back(r);
  endtask

  // values biased towards the edges as well as fully random ones
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 6))
      0:       v = $urandom_range(0, 99);
      1:       v = 32'hFFFF_FFFF;
      2:       v = 32'h1 << $urandom_range(0, 31);
      3:       v = ~(32'h1 << $urandom_range(0, 31));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic ita_pkg::fmt_t pick_format();
    ita_pkg::fmt_t f;
    case ($urandom_range(0, 9))
      0, 1, 2: f = ita_pkg::FMT_HEX;
      3, 4, 5: f = ita_pkg::FMT_DEC;
      6, 7, 8: f = ita_pkg::FMT_BIN;
      default: f = ita_pkg::FMT_NONE;
    endcase
    return f;
  endfunction

  // driver: one request at a time from the queue, with random gaps
  always @(posedge clk) begin : drive_requests
    fmt_request_t nxt;
    logic         load;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_text(ita_pkg::fmt_t'(in_action), in_number_value, in_append_newline);
      end
      load = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (queued_requests.size() > 0) begin
        // a draining request holds back until all text has come out
        if (!(queued_requests[0].wait_drained && pending_chars.size() != 0)) load = 1'b1;
      end
      if (load) begin
        nxt = queued_requests.pop_front();
        in_action         <= nxt.action;
        in_number_value   <= nxt.value;
        in_append_newline <= nxt.newline;
        rx_stall_pct      <= nxt.stall_pct;
        if ($urandom_range(1, 100) <= nxt.gap_pct) send_gap = $urandom_range(1, 16);
      end
      in_valid <= load;
    end
  end

  // receiver back-pressure in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(1, 100) <= rx_stall_pct) recv_stall = $urandom_range(1, 16);
    end
  end

  // monitor: compare each character with the oldest expected one
  always @(posedge clk) begin : check_chars
    text_char_t exp_c;
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t unexpected character: expected none actual %h last %b",
                 $time, out_ascii_char, out_last_char);
        error_count++;
      end else begin
        exp_c = pending_chars.pop_front();
        if (out_ascii_char !== exp_c.ch) begin
          $display("%0t ascii_char mismatch: expected %h actual %h",
                   $time, exp_c.ch, out_ascii_char);
          error_count++;
        end
        if (out_last_char !== exp_c.is_last) begin
          $display("%0t last_char mismatch: expected %b actual %b",
                   $time, exp_c.is_last, out_last_char);
          error_count++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    ita_pkg::fmt_t f;
    // directed: extremes, every format, none with and without newline
    phase_gap_pct   = 20;
    phase_stall_pct = 10;
    add_request(ita_pkg::FMT_HEX, 32'h0000_0000, 1'b0);
    add_request(ita_pkg::FMT_HEX, 32'hFFFF_FFFF, 1'b0);
    add_request(ita_pkg::FMT_HEX, 32'h1234_5678, 1'b1);
    add_request(ita_pkg::FMT_HEX, 32'hDEAD_BEEF, 1'b0);
    add_request(ita_pkg::FMT_HEX, 32'hA5C3_0F96, 1'b1);
    add_request(ita_pkg::FMT_DEC, 32'h0000_0000, 1'b0);
    add_request(ita_pkg::FMT_DEC, 32'hFFFF_FFFF, 1'b1);
    add_request(ita_pkg::FMT_DEC, 32'd1234567890, 1'b0);
    add_request(ita_pkg::FMT_DEC, 32'd9, 1'b0);
    add_request(ita_pkg::FMT_DEC, 32'h8000_0000, 1'b1);
    add_request(ita_pkg::FMT_BIN, 32'h0000_0000, 1'b0);
    add_request(ita_pkg::FMT_BIN, 32'hFFFF_FFFF, 1'b0);
    add_request(ita_pkg::FMT_BIN, 32'hA5A5_A5A5, 1'b1);
    add_request(ita_pkg::FMT_BIN, 32'h5A5A_5A5A, 1'b0);
    add_request(ita_pkg::FMT_NONE, 32'hFFFF_FFFF, 1'b0);
    add_request(ita_pkg::FMT_NONE, 32'h0000_0000, 1'b1);
    add_request(ita_pkg::FMT_NONE, 32'h1234_5678, 1'b0);
    add_request(ita_pkg::FMT_NONE, 32'h8765_4321, 1'b0);
    add_request(ita_pkg::FMT_HEX, 32'h0000_000F, 1'b1);
    add_request(ita_pkg::FMT_DEC, 32'd999999999, 1'b0, 1'b1);
    add_request(ita_pkg::FMT_NONE, 32'h0, 1'b1);
    add_request(ita_pkg::FMT_BIN, 32'h0000_0001, 1'b1);

    // random phases with varying idle levels, one drained pause each
    for (int p = 0; p < 6; p++) begin
      case ($urandom_range(0, 3))
        0:       begin phase_gap_pct = 0;  phase_stall_pct = 0;  end
        1:       begin phase_gap_pct = 10; phase_stall_pct = 5;  end
        2:       begin phase_gap_pct = 40; phase_stall_pct = 20; end
        default: begin phase_gap_pct = 5;  phase_stall_pct = 40; end
      endcase
      if (p == 5) begin
        phase_gap_pct   = 0;
        phase_stall_pct = 0;
      end
      for (int i = 0; i < 60; i++) begin
        f = pick_format();
        add_request(f, pick_value(), 1'($urandom_range(0, 1)), i == 30);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (queued_requests.size() != 0 || in_valid) @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (error_count == 0) begin
      $display("integer_to_ascii_formatter_top verification clean");
    end else begin
      $display("integer_to_ascii_formatter_top verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(2 * HALF_PERIOD * 1000000);
    $display("integer_to_ascii_formatter_top verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/ita_pkg.sv
design/ita_front.sv
design/ita_queue.sv
design/ita_back.sv
design/integer_to_ascii_formatter_top.sv
tb/tb_integer_to_ascii_formatter_top.sv
